// ----- rtl/resolver_angle_from_sin_cos_macros.svh -----
// assertion macros shared by the resolver angle checker
// no dependencies
`ifndef RESOLVER_ANGLE_FROM_SIN_COS_MACROS_SVH
`define RESOLVER_ANGLE_FROM_SIN_COS_MACROS_SVH

// property holds at every clock edge outside reset
`define RASC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RASC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rasc_pkg.sv -----
// types and constants for the resolver angle pipeline
// used by every module of the block
package rasc_pkg;

   localparam int ANGLE_BITS = 34;
   localparam int MAG_BITS   = 32;
   localparam int CPR_BITS   = 16;
   localparam int COUNT_BITS = 16;
   localparam int ATAN_LEN   = 24;
   localparam int FRAC_BITS  = 16;

   localparam logic [CPR_BITS-1:0] CPR_RESET = 16'd10000;

   localparam logic signed [ANGLE_BITS-1:0] HALF_TURN     = 34'sh0_8000_0000;
   localparam logic signed [ANGLE_BITS-1:0] NEG_HALF_TURN = -34'sh0_8000_0000;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic [CPR_BITS-1:0]          cpr_type;
   typedef logic signed [COUNT_BITS-1:0] count_type;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

// ----- rtl/rasc_front.sv -----
// input stage: offset removal, fixed-point scaling and left half-plane turn
// depends on rasc_pkg
module rasc_front import rasc_pkg::*; #(
   parameter int SAMPLE_BITS = 12,
   parameter int XW          = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic [SAMPLE_BITS-1:0] in_sine,
   input  logic [SAMPLE_BITS-1:0] in_cosine,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic signed [XW-1:0]   out_x,
   output logic signed [XW-1:0]   out_y,
   output angle_type              out_z
);

   logic                        valid_ff;
   logic signed [SAMPLE_BITS-1:0] y_c;
   logic signed [SAMPLE_BITS-1:0] x_c;
   logic signed [XW-1:0]        y_w;
   logic signed [XW-1:0]        x_w;
   logic signed [XW-1:0]        x_in, y_in, x_ff, y_ff;
   angle_type                   z_in, z_ff;

   assign y_c = {~in_sine[SAMPLE_BITS-1], in_sine[SAMPLE_BITS-2:0]};
   assign x_c = {~in_cosine[SAMPLE_BITS-1], in_cosine[SAMPLE_BITS-2:0]};
   assign y_w = {{(XW-SAMPLE_BITS-FRAC_BITS){y_c[SAMPLE_BITS-1]}}, y_c, {FRAC_BITS{1'b0}}};
   assign x_w = {{(XW-SAMPLE_BITS-FRAC_BITS){x_c[SAMPLE_BITS-1]}}, x_c, {FRAC_BITS{1'b0}}};

   always_comb begin
      x_in = x_w;
      y_in = y_w;
      z_in = '0;
      if (x_w[XW-1]) begin
         x_in = -x_w;
         y_in = -y_w;
         z_in = y_w[XW-1] ? NEG_HALF_TURN : HALF_TURN;
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

// ----- rtl/rasc_stage.sv -----
// one vectoring micro-rotation of the cordic, registered
// depends on rasc_pkg for the arctangent table
module rasc_stage import rasc_pkg::*; #(
   parameter int XW   = 31,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  angle_type            in_z,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output angle_type            out_z
);

   localparam angle_type ATAN_STEP = {2'b00, ATAN_TURNS[STEP]};

   logic                 valid_ff;
   logic signed [XW-1:0] dx, dy;
   logic signed [XW-1:0] x_in, y_in, x_ff, y_ff;
   angle_type            z_in, z_ff;

   assign dx = in_y >>> STEP;
   assign dy = in_x >>> STEP;

   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = in_z;
      if (in_y != '0) begin
         if (!in_y[XW-1]) begin
            x_in = in_x + dx;
            y_in = in_y - dy;
            z_in = in_z + ATAN_STEP;
         end else begin
            x_in = in_x - dx;
            y_in = in_y + dy;
            z_in = in_z - ATAN_STEP;
         end
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

// ----- rtl/rasc_scale.sv -----
// angle to count conversion: clamp and magnitude, multiply, sign restore
// depends on rasc_pkg
module rasc_scale import rasc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  angle_type in_z,
   input  cpr_type   counts_per_rev,
   output logic      out_valid,
   input  logic      out_stall,
   output count_type out_count
);

   logic                         valid_a_ff, valid_b_ff, valid_c_ff;
   logic                         stall_a, stall_b, stall_c;
   angle_type                    z_clamp;
   angle_type                    z_abs;
   logic [MAG_BITS-1:0]          mag_in, mag_ff;
   logic                         neg_a_ff, neg_b_ff;
   logic [MAG_BITS+CPR_BITS-1:0] prod;
   logic [COUNT_BITS-1:0]        cnt_in, cnt_ff;
   count_type                    count_in, count_ff;

   // clamp and magnitude
   always_comb begin
      z_clamp = in_z;
      if (in_z > HALF_TURN) begin
         z_clamp = HALF_TURN;
      end else if (in_z < NEG_HALF_TURN) begin
         z_clamp = NEG_HALF_TURN;
      end
      z_abs  = z_clamp[ANGLE_BITS-1] ? -z_clamp : z_clamp;
      mag_in = z_abs[MAG_BITS-1:0];
   end

   assign prod     = mag_ff * counts_per_rev;
   assign cnt_in   = prod[MAG_BITS+CPR_BITS-1:MAG_BITS];
   assign count_in = neg_b_ff ? -count_type'(cnt_ff) : count_type'(cnt_ff);

   assign stall_c  = valid_c_ff && out_stall;
   assign stall_b  = valid_b_ff && stall_c;
   assign stall_a  = valid_a_ff && stall_b;
   assign in_stall = stall_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (!stall_a) begin
            valid_a_ff <= in_valid;
         end
         if (!stall_b) begin
            valid_b_ff <= valid_a_ff;
         end
         if (!stall_c) begin
            valid_c_ff <= valid_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !stall_a) begin
         mag_ff   <= mag_in;
         neg_a_ff <= z_clamp[ANGLE_BITS-1];
      end
      if (valid_a_ff && !stall_b) begin
         cnt_ff   <= cnt_in;
         neg_b_ff <= neg_a_ff;
      end
      if (valid_b_ff && !stall_c) begin
         count_ff <= count_in;
      end
   end

   assign out_valid = valid_c_ff;
   assign out_count = count_ff;

endmodule

// ----- rtl/resolver_angle_from_sin_cos.sv -----
// channel   | direction | handshake       | payload
// req       | in        | valid / stall   | sine_sample, cosine_sample
// rsp       | out       | valid / stall   | angle_count
// csr       | in        | valid / ready   | counts_per_rev
//
// one transfer per cycle sustained while rsp_stall is low; one register per
// micro-rotation plus an input stage and three scaling stages
// synchronous reset clears all valid bits and sets counts_per_rev to 10000
// every stage holds under stall and an empty stage still takes a transfer,
// so input is taken while a result waits at the output register and an earlier stage is empty
// depends on rasc_pkg, rasc_front, rasc_stage, rasc_scale
module resolver_angle_from_sin_cos import rasc_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sine_sample,
   input  logic [SAMPLE_BITS-1:0] req_cosine_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [COUNT_BITS-1:0] rsp_angle_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CPR_BITS-1:0]    csr_counts_per_rev
);

   localparam int XW = SAMPLE_BITS + FRAC_BITS + 3;

   cpr_type              cpr_ff;
   logic                 valid_w [CORDIC_STEPS+1];
   logic                 stall_w [CORDIC_STEPS+1];
   logic signed [XW-1:0] x_w     [CORDIC_STEPS+1];
   logic signed [XW-1:0] y_w     [CORDIC_STEPS+1];
   angle_type            z_w     [CORDIC_STEPS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff <= CPR_RESET;
      end else if (csr_valid && csr_ready) begin
         cpr_ff <= csr_counts_per_rev;
      end
   end

   rasc_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .XW          (XW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_sine   (req_sine_sample),
      .in_cosine (req_cosine_sample),
      .out_valid (valid_w[0]),
      .out_stall (stall_w[0]),
      .out_x     (x_w[0]),
      .out_y     (y_w[0]),
      .out_z     (z_w[0])
   );

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      rasc_stage #(
         .XW   (XW),
         .STEP (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[k]),
         .in_stall  (stall_w[k]),
         .in_x      (x_w[k]),
         .in_y      (y_w[k]),
         .in_z      (z_w[k]),
         .out_valid (valid_w[k+1]),
         .out_stall (stall_w[k+1]),
         .out_x     (x_w[k+1]),
         .out_y     (y_w[k+1]),
         .out_z     (z_w[k+1])
      );
   end

   rasc_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (valid_w[CORDIC_STEPS]),
      .in_stall       (stall_w[CORDIC_STEPS]),
      .in_z           (z_w[CORDIC_STEPS]),
      .counts_per_rev (cpr_ff),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_count      (rsp_angle_count)
   );

endmodule

// ----- rtl/rasc_checker.sv -----
// port-level checks for the resolver angle block, bound to the top level
// depends on rasc_pkg and resolver_angle_from_sin_cos_macros.svh
`include "resolver_angle_from_sin_cos_macros.svh"

module rasc_checker import rasc_pkg::*; #(
   parameter int SAMPLE_BITS = 12
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [SAMPLE_BITS-1:0] req_sine_sample,
   input logic [SAMPLE_BITS-1:0] req_cosine_sample,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic signed [COUNT_BITS-1:0] rsp_angle_count
);

   `RASC_ASSERT(a_stall_from_output, clock, reset,
      req_stall |-> (rsp_valid && rsp_stall), "input stalled without a stalled result")
   `RASC_ASSERT(a_count_range, clock, reset,
      rsp_valid |-> (rsp_angle_count != 16'sh8000), "angle count beyond half a turn")
   `RASC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_angle_count), "stalled result dropped or changed")
   `RASC_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_sine_sample) && $stable(req_cosine_sample),
      "stalled request dropped or changed")
   `RASC_ASSERT(a_reset_empty, clock, reset,
      $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

bind resolver_angle_from_sin_cos rasc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rasc_checker (.*);

// ----- tb/tb_resolver_angle_from_sin_cos.sv -----
// self-checking testbench for resolver_angle_from_sin_cos: directed table, then random
// sample pairs over several counts_per_rev settings, each result checked in order
// depends on rasc_pkg and the resolver_angle_from_sin_cos rtl
module tb_resolver_angle_from_sin_cos;
   import rasc_pkg::*;

   localparam int CORDIC_STEPS = 16;
   localparam int SAMPLE_BITS  = 12;
   localparam int PIPE_DEPTH   = CORDIC_STEPS + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 64;
   localparam int PHASE_PAIRS  = 250;
   localparam int NUM_ROWS     = 22;
   localparam logic [SAMPLE_BITS-1:0] MID = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] TOP = '1;

   // atan(2^-i) in units of 2^-32 turn
   localparam longint ARCTAN_STEP [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   typedef struct {
      logic [SAMPLE_BITS-1:0] sine;
      logic [SAMPLE_BITS-1:0] cosine;
      bit                     known;
      count_type              angle;
   } pair_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sine_sample;
   logic [SAMPLE_BITS-1:0] req_cosine_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   count_type              rsp_angle_count;
   logic                   csr_valid;
   logic                   csr_ready;
   cpr_type                csr_counts_per_rev;

   count_type angle_due[$];
   cpr_type   cpr_now;
   bit        send_idle;
   bit        take_idle;
   bit        hold_request;
   int        stall_left;
   int        cycle_count;
   int        mismatch_count;
   int        pairs_sent;
   int        angles_checked;
   int        scalings_used;

   resolver_angle_from_sin_cos #(
      .CORDIC_STEPS(CORDIC_STEPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sine_sample   (req_sine_sample),
      .req_cosine_sample (req_cosine_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_angle_count   (rsp_angle_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_counts_per_rev(csr_counts_per_rev)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic count_type predict_angle(input logic [SAMPLE_BITS-1:0] sin_raw,
                                               input logic [SAMPLE_BITS-1:0] cos_raw,
                                               input cpr_type cpr);
      longint x, y, z, dx, dy, half, cnt;
      longint unsigned mag, scaled;
      y = longint'(sin_raw) - longint'(MID);
      x = longint'(cos_raw) - longint'(MID);
      z = 0;
      half = longint'(1) << 31;
      if (x == 0 && y == 0) return '0;
      x = x * 65536;
      y = y * 65536;
      if (x < 0) begin
         z = (y >= 0) ? half : -half;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (y != 0) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx;
               y -= dy;
               z += ARCTAN_STEP[i];
            end else begin
               x -= dx;
               y += dy;
               z -= ARCTAN_STEP[i];
            end
         end
      end
      if (z > half) z = half;
      if (z < -half) z = -half;
      mag = (z < 0) ? longint'(-z) : longint'(z);
      scaled = (mag * longint'(cpr)) >> 32;
      cnt = longint'(scaled);
      if (z < 0) cnt = -cnt;
      if (cnt > 32767) cnt = 32767;
      if (cnt < -32768) cnt = -32768;
      return count_type'(cnt);
   endfunction

   // receive side: check every result transfer, then decide next stall
   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (angle_due.size() == 0) begin
               $error("angle_count: no result expected, actual %0d", rsp_angle_count);
               mismatch_count++;
            end else begin
               if (rsp_angle_count !== angle_due[0]) begin
                  $error("angle_count: expected %0d, actual %0d",
                         angle_due[0], rsp_angle_count);
                  mismatch_count++;
               end
               void'(angle_due.pop_front());
               angles_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (take_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pair(input logic [SAMPLE_BITS-1:0] s, input logic [SAMPLE_BITS-1:0] c,
                            input bit known, input count_type fixed);
      if (send_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sine_sample <= s;
      req_cosine_sample <= c;
      do @(posedge clock); while (req_stall);
      angle_due.push_back(known ? fixed : predict_angle(s, c, cpr_now));
      pairs_sent++;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      wait (angle_due.size() == 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_cpr(input cpr_type value);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_counts_per_rev <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cpr_now = value;
      scalings_used++;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic [SAMPLE_BITS-1:0] v;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = TOP;
         2: v = MID;
         3: v = SAMPLE_BITS'(MID - 1);
         4: v = SAMPLE_BITS'(MID + 1);
         default: v = SAMPLE_BITS'($urandom_range(0, TOP));
      endcase
      return v;
   endfunction

   task automatic send_random_pair();
      logic [SAMPLE_BITS-1:0] s, c;
      int sel;
      sel = $urandom_range(0, 19);
      s = SAMPLE_BITS'($urandom_range(0, TOP));
      c = SAMPLE_BITS'($urandom_range(0, TOP));
      if (sel < 3) begin
         if ($urandom_range(0, 1)) s = MID;
         else c = MID;
      end else if (sel < 5) begin
         s = SAMPLE_BITS'(MID + $urandom_range(0, 6) - 3);
         c = SAMPLE_BITS'(MID + $urandom_range(0, 6) - 3);
      end else if (sel < 7) begin
         s = pick_sample();
         c = pick_sample();
      end else if (sel < 8) begin
         c = ($urandom_range(0, 1)) ? s : TOP - s;
      end
      send_pair(s, c, 1'b0, '0);
   endtask

   pair_row_type pair_table [NUM_ROWS] = '{
      '{MID,                    MID,                    1'b1, 16'sd0},
      '{MID,                    TOP,                    1'b1, 16'sd0},
      '{MID,                    SAMPLE_BITS'(MID + 1),  1'b1, 16'sd0},
      '{MID,                    12'h000,                1'b1, 16'sd5000},
      '{MID,                    SAMPLE_BITS'(MID - 1),  1'b1, 16'sd5000},
      '{SAMPLE_BITS'(MID - 1),  12'h000,                1'b0, 16'sd0},
      '{12'h000,                12'h000,                1'b0, 16'sd0},
      '{TOP,                    TOP,                    1'b0, 16'sd0},
      '{12'h000,                TOP,                    1'b0, 16'sd0},
      '{TOP,                    12'h000,                1'b0, 16'sd0},
      '{TOP,                    MID,                    1'b0, 16'sd0},
      '{12'h000,                MID,                    1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID + 1),  MID,                    1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID - 1),  MID,                    1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID + 1),  SAMPLE_BITS'(MID - 1),  1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID - 1),  SAMPLE_BITS'(MID - 1),  1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID + 1),  SAMPLE_BITS'(MID + 1),  1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID - 1),  SAMPLE_BITS'(MID + 1),  1'b0, 16'sd0},
      '{12'hAAA,                12'h555,                1'b0, 16'sd0},
      '{12'h555,                12'hAAA,                1'b0, 16'sd0},
      '{TOP,                    SAMPLE_BITS'(MID + 1),  1'b0, 16'sd0},
      '{SAMPLE_BITS'(MID + 1),  12'h000,                1'b0, 16'sd0}
   };

   cpr_type phase_cpr [7];

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sine_sample = '0;
      req_cosine_sample = '0;
      csr_valid = 1'b0;
      csr_counts_per_rev = '0;
      cpr_now = CPR_RESET;
      send_idle = 1'b1;
      take_idle = 1'b1;
      hold_request = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      pairs_sent = 0;
      angles_checked = 0;
      scalings_used = 1;
      phase_cpr = '{16'd65535, 16'd1, cpr_type'($urandom_range(2, 65534)), 16'd360,
                    cpr_type'($urandom_range(2, 65534)), 16'd16384, CPR_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset scaling
      foreach (pair_table[r])
         send_pair(pair_table[r].sine, pair_table[r].cosine,
                   pair_table[r].known, pair_table[r].angle);

      foreach (phase_cpr[p]) begin
         write_cpr(phase_cpr[p]);
         if (p == 2) hold_request = 1'b1;
         if (p == 6) begin
            send_idle = 1'b0;
            take_idle = 1'b0;
         end
         repeat (PHASE_PAIRS) send_random_pair();
      end
      drain_pipe();

      $display("checked %0d angle results from %0d sample pairs over %0d scalings,",
               angles_checked, pairs_sent, scalings_used);
      $display("including both axes, all quadrants, mid-scale and a long output hold-off");
      if (mismatch_count == 0 && angle_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
